FILE: src/hhtd_pkg.sv
// Shared types, constants and the fixed decode tree of the HPACK Huffman decoder.
`default_nettype none

package hhtd_pkg;

    // Tree and counter geometry.
    localparam int TREE_NODES = 256;
    localparam int NODE_W     = $clog2(TREE_NODES);
    localparam int COUNT_W    = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Reset value of the output limit register.
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd4096;

    // Register index of the output limit, taken from paddr[2].
    localparam logic REG_OUTPUT_LIMIT = 1'b0;

    // Tree word layout: zero child high, one child low, bit 15 marks a leaf.
    localparam int LEAF_BIT = 15;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE,
        S_STATUS
    } state_t;

    // End-of-string status codes; ST_OK also means no error held.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_TRUNC    = 2'd2,
        ST_EOS      = 2'd3
    } status_t;

    // One result item as handed from the walker to the output register.
    typedef struct packed {
        logic               is_status;
        logic [7:0]         symbol;
        status_t            status_code;
        logic [COUNT_W-1:0] decoded_count;
        logic               last_result;
    } result_t;

    // Fixed decode tree.
    localparam logic [31:0] DECODE_TREE [TREE_NODES] = '{
        32'd65538, 32'd196612, 32'd983056, 32'd327686,
        32'd524297, 32'd2150662193, 32'd2150760455, 32'd2149613615,
        32'd655371, 32'd786445, 32'd2150858849, 32'd2154004581,
        32'd2154397807, 32'd2155085838, 32'd2149941294, 32'd1114130,
        32'd2031648, 32'd1245204, 32'd1638426, 32'd1376278,
        32'd1507352, 32'd2150924341, 32'd2151055415, 32'd2151186489,
        32'd2151317565, 32'd1769500, 32'd1900574, 32'd2153021540,
        32'd2154266728, 32'd2154594413, 32'd2154725488, 32'd2162722,
        32'd2949166, 32'd2293796, 32'd2555944, 32'd2154987635,
        32'd2424870, 32'd2150006828, 32'd2150465601, 32'd2687018,
        32'd2818092, 32'd2151972934, 32'd2152169549, 32'd2152628307,
        32'd2153742434, 32'd3080240, 32'd3604536, 32'd3211314,
        32'd3342388, 32'd2154201205, 32'd2155249783, 32'd2155380857,
        32'd3473462, 32'd2151383106, 32'd2151907397, 32'd3735610,
        32'd4128832, 32'd3866684, 32'd3997758, 32'd2152300623,
        32'd2152759381, 32'd2153283690, 32'd2154528890, 32'd4259906,
        32'd4653128, 32'd4390980, 32'd4522054, 32'd2149744681,
        32'd2152235082, 32'd2152431692, 32'd2152824914, 32'd4784202,
        32'd4915276, 32'd2153152599, 32'd2153349210, 32'd2154889293,
        32'd5111887, 32'd2150137898, 32'd2150334527, 32'd5242961,
        32'd2153480285, 32'd5374035, 32'd2155643006, 32'd5505109,
        32'd2149679143, 32'd5636183, 32'd2149810270, 32'd5767257,
        32'd2149875774, 32'd2151678042, 32'd5963868, 32'd2151448699,
        32'd2155675741, 32'd2153775198, 32'd6226016, 32'd6357090,
        32'd10420384, 32'd6488164, 32'd8454274, 32'd6619238,
        32'd7536756, 32'd6750312, 32'd7143534, 32'd6881386,
        32'd7012460, 32'd2158264485, 32'd2158395559, 32'd2158526633,
        32'd2158657707, 32'd7274608, 32'd7405682, 32'd2158788781,
        32'd2158919855, 32'd2159050929, 32'd2159182003, 32'd7667830,
        32'd8061052, 32'd7798904, 32'd7929978, 32'd2159313077,
        32'd2159444151, 32'd2159575225, 32'd2159706299, 32'd8192126,
        32'd8323200, 32'd2159837373, 32'd2159968447, 32'd2160099521,
        32'd2160230595, 32'd8585348, 32'd9502866, 32'd8716422,
        32'd9109644, 32'd8847496, 32'd8978570, 32'd2160361669,
        32'd2160492743, 32'd2160623817, 32'd2160754891, 32'd9240718,
        32'd9371792, 32'd2160885965, 32'd2161017039, 32'd2161148113,
        32'd2161279187, 32'd9633940, 32'd10027162, 32'd9765014,
        32'd9896088, 32'd2161410261, 32'd2161541335, 32'd2161672409,
        32'd2161803483, 32'd10158236, 32'd10289310, 32'd2161934557,
        32'd2162065631, 32'd2162196705, 32'd2162327779, 32'd10551458,
        32'd12714179, 32'd10682532, 32'd11600050, 32'd10813606,
        32'd11206828, 32'd10944680, 32'd11075754, 32'd2162458853,
        32'd2162589927, 32'd2162721001, 32'd2162852075, 32'd11337902,
        32'd11468976, 32'd2162983149, 32'd2163114223, 32'd2163245297,
        32'd2163376371, 32'd11731124, 32'd12124346, 32'd11862198,
        32'd11993272, 32'd2163507445, 32'd2163638519, 32'd2163769593,
        32'd2163900667, 32'd12255420, 32'd12386494, 32'd2164031741,
        32'd2164162815, 32'd2164261055, 32'd12583105, 32'd2147516417,
        32'd2147647491, 32'd2147778565, 32'd12845253, 32'd14811363,
        32'd12976327, 32'd13893845, 32'd13107401, 32'd13500623,
        32'd13238475, 32'd13369549, 32'd2147909639, 32'd2148040713,
        32'd2148171787, 32'd2148302861, 32'd13631697, 32'd13762771,
        32'd2148433935, 32'd2148565009, 32'd2148696083, 32'd2148827157,
        32'd14024919, 32'd14418141, 32'd14155993, 32'd14287067,
        32'd2148958231, 32'd2149089305, 32'd2149220379, 32'd2149351453,
        32'd14549215, 32'd14680289, 32'd2149482527, 32'd2153545855,
        32'd2155905153, 32'd2156036227, 32'd14942437, 32'd15859955,
        32'd15073511, 32'd15466733, 32'd15204585, 32'd15335659,
        32'd2156167301, 32'd2156298375, 32'd2156429449, 32'd2156560523,
        32'd15597807, 32'd15728881, 32'd2156691597, 32'd2156822671,
        32'd2156953745, 32'd2157084819, 32'd15991029, 32'd16384251,
        32'd16122103, 32'd16253177, 32'd2157215893, 32'd2157346967,
        32'd2157478041, 32'd2157609115, 32'd16515325, 32'd16646399,
        32'd2157740189, 32'd2157871263, 32'd2158002337, 32'd2158133411
    };

endpackage

`default_nettype wire

FILE: src/hhtd_apb_regs.sv
// APB register block holding the per-string output limit.
`default_nettype none

module hhtd_apb_regs
    import hhtd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [COUNT_W-1:0]    output_limit
);

    logic [COUNT_W-1:0] limit_reg;
    logic [COUNT_W-1:0] limit_next;
    logic               sel_limit;
    logic               write_en;

    // Register decode and access phase of a write transaction.
    assign sel_limit = (paddr[2] == REG_OUTPUT_LIMIT);
    assign write_en  = psel && penable && pwrite && sel_limit;
    assign pready    = 1'b1;

    always_comb
    begin
        limit_next = limit_reg;
        if (write_en)
        begin
            limit_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    // Read data for the selected register.
    always_comb
    begin
        prdata = '0;
        if (sel_limit)
        begin
            prdata = {{(APB_DATA_W-COUNT_W){1'b0}}, limit_reg};
        end
    end

    assign output_limit = limit_reg;

endmodule

`default_nettype wire

FILE: src/hhtd_walker.sv
// Bit-serial tree walker: one tree lookup per cycle while not stalled, under a small sequencer.
`default_nettype none

module hhtd_walker
    import hhtd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         coded_byte,
    input  wire logic               last_byte,
    input  wire logic [COUNT_W-1:0] output_limit,
    input  wire logic               out_free,
    output logic                    push,
    output result_t                 push_item
);

    state_t             state_reg, state_next;
    logic [7:0]         byte_reg, byte_next;
    logic               last_reg, last_next;
    logic [2:0]         bit_reg, bit_next;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    status_t            err_reg, err_next;
    logic               fin_reg, fin_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [7:0]         pend_sym_reg, pend_sym_next;
    logic [COUNT_W-1:0] pend_cnt_reg, pend_cnt_next;

    logic [31:0]        tree_word;
    logic               cur_bit;
    logic [15:0]        child;
    logic               is_leaf;
    logic               is_eos;
    logic [COUNT_W-1:0] count_inc;
    logic [6:0]         pad;
    logic               clean_end;
    logic               halted;
    logic               step_stall;
    status_t            end_code;

    // Shared lookup unit: one tree node and one coded bit per cycle while not stalled.
    assign tree_word  = DECODE_TREE[node_reg];
    assign cur_bit    = byte_reg[3'd7 - bit_reg];
    assign child      = cur_bit ? tree_word[15:0] : tree_word[31:16];
    assign is_leaf    = child[LEAF_BIT];
    assign is_eos     = is_leaf && (child[LEAF_BIT-1:8] != '0);
    assign count_inc  = count_reg + 16'd1;
    assign pad        = 7'h7F >> bit_reg;
    assign clean_end  = last_reg && ((byte_reg[6:0] & pad) == pad);
    assign halted     = (err_reg != ST_OK) || fin_reg;
    assign step_stall = is_leaf && !is_eos && pend_valid_reg && !out_free;

    // Status reported at the end of the string.
    always_comb
    begin
        if (err_reg != ST_OK)
        begin
            end_code = err_reg;
        end
        else if (fin_reg)
        begin
            end_code = ST_OK;
        end
        else
        begin
            end_code = ST_TRUNC;
        end
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (halted || is_eos)
                begin
                    state_next = S_DONE;
                end
                else if (!step_stall && (bit_reg == 3'd7))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = last_reg ? S_STATUS : S_IDLE;
                end
            end
            S_STATUS:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs: input handshake and result pushes.
    always_comb
    begin
        in_ready                = 1'b0;
        push                    = 1'b0;
        push_item.is_status     = 1'b0;
        push_item.symbol        = pend_sym_reg;
        push_item.status_code   = ST_OK;
        push_item.decoded_count = pend_cnt_reg;
        push_item.last_result   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_WALK:
            begin
                // A new symbol displaces the held one, which is then not final.
                push = !halted && is_leaf && !is_eos && pend_valid_reg && out_free;
            end
            S_DONE:
            begin
                push                  = pend_valid_reg && out_free;
                push_item.last_result = !last_reg;
            end
            S_STATUS:
            begin
                push                    = out_free;
                push_item.is_status     = 1'b1;
                push_item.symbol        = 8'd0;
                push_item.status_code   = end_code;
                push_item.decoded_count = (err_reg == ST_EOS) ? '0 : count_reg;
                push_item.last_result   = 1'b1;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // Datapath next values for the walk, the counters and the held symbol.
    always_comb
    begin
        byte_next       = byte_reg;
        last_next       = last_reg;
        bit_next        = bit_reg;
        node_next       = node_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        fin_next        = fin_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_cnt_next   = pend_cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next = coded_byte;
                    last_next = last_byte;
                    bit_next  = 3'd0;
                    // A limit already reached stops the byte before any bit.
                    if (!halted && (count_reg >= output_limit))
                    begin
                        err_next = ST_OVERFLOW;
                    end
                end
            end
            S_WALK:
            begin
                if (!halted)
                begin
                    if (!is_leaf)
                    begin
                        node_next = child[NODE_W-1:0];
                        bit_next  = bit_reg + 3'd1;
                    end
                    else if (is_eos)
                    begin
                        err_next   = ST_EOS;
                        count_next = '0;
                        node_next  = '0;
                    end
                    else if (!step_stall)
                    begin
                        count_next      = count_inc;
                        pend_valid_next = 1'b1;
                        pend_sym_next   = child[7:0];
                        pend_cnt_next   = count_inc;
                        node_next       = '0;
                        bit_next        = bit_reg + 3'd1;
                        if (clean_end)
                        begin
                            fin_next = 1'b1;
                        end
                        else if (count_inc >= output_limit)
                        begin
                            err_next = ST_OVERFLOW;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (pend_valid_reg && out_free)
                begin
                    pend_valid_next = 1'b0;
                end
            end
            S_STATUS:
            begin
                if (out_free)
                begin
                    node_next  = '0;
                    count_next = '0;
                    err_next   = ST_OK;
                    fin_next   = 1'b0;
                end
            end
            default:
            begin
                node_next = node_reg;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bit_reg        <= 3'd0;
            node_reg       <= '0;
            count_reg      <= '0;
            err_reg        <= ST_OK;
            fin_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bit_reg        <= bit_next;
            node_reg       <= node_next;
            count_reg      <= count_next;
            err_reg        <= err_next;
            fin_reg        <= fin_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        pend_sym_reg <= pend_sym_next;
        pend_cnt_reg <= pend_cnt_next;
    end

endmodule

`default_nettype wire

FILE: src/hpack_huffman_tree_decoder_top.sv
// HPACK Huffman decoder top level: tree walker, output register and APB registers.
//
// Usage: coded bytes enter on the input channel (in_valid/in_ready) with
// coded_byte and last_byte; each byte is walked MSB first through the fixed
// decode tree, one tree node per clock while the walk is not stalled. Decoded
// symbols and, on the last byte of a string, one status transaction leave on
// the output channel (out_valid/out_ready). last_result marks the final
// transaction of a byte. The single tree lookup unit sets the rate: after
// acceptance a byte is walked bit by bit, then its held symbol is released,
// and on a last byte the status is sent before the block is ready again.
// A byte cut short by an error or a clean end ends its walk early.
// The last decoded symbol of a byte is held back so that its last_result
// flag is known; results reach the ports in the cycle after they are produced.
// When the receiver stalls, the output register holds its transaction and the
// walker pauses at its next result; no transaction is lost or repeated.
// Reset clears the walk state, count and held error, empties the output
// register and sets output_limit to 4096. output_limit is written over APB at
// address 0 by the user only while idle; the block does not enforce this.
`default_nettype none

module hpack_huffman_tree_decoder_top
    import hhtd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            coded_byte,
    input  wire logic                  last_byte,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       is_status,
    output logic      [7:0]            symbol,
    output logic      [1:0]            status_code,
    output logic      [COUNT_W-1:0]    decoded_count,
    output logic                       last_result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [COUNT_W-1:0] output_limit;
    logic               out_free;
    logic               push;
    result_t            push_item;
    logic               out_valid_reg, out_valid_next;
    result_t            out_item_reg, out_item_next;

    hhtd_apb_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .output_limit (output_limit)
    );

    hhtd_walker u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .coded_byte   (coded_byte),
        .last_byte    (last_byte),
        .output_limit (output_limit),
        .out_free     (out_free),
        .push         (push),
        .push_item    (push_item)
    );

    // Output register: free when empty or being taken this cycle.
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_item_next  = push_item;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid     = out_valid_reg;
    assign is_status     = out_item_reg.is_status;
    assign symbol        = out_item_reg.symbol;
    assign status_code   = out_item_reg.status_code;
    assign decoded_count = out_item_reg.decoded_count;
    assign last_result   = out_item_reg.last_result;

    // A status transaction always closes the results of its byte.
    a_status_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_status |-> last_result)
        else $error("status transaction without last_result");

    // Symbol transactions carry no status code.
    a_symbol_code_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_status |-> status_code == ST_OK)
        else $error("symbol transaction with a status code");

    // An EOS error reports a zero count.
    a_eos_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_status && (status_code == ST_EOS) |-> decoded_count == '0)
        else $error("EOS status with nonzero count");

    // The walker never produces results while waiting for a new byte.
    a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !push)
        else $error("result produced while idle");

endmodule

`default_nettype wire

FILE: tb/tb_hpack_huffman_tree_decoder_top.sv
// Self-checking testbench for the HPACK Huffman tree decoder top level.
module tb_hpack_huffman_tree_decoder_top;
    import hhtd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 24;
    localparam int EOS_SYMBOL    = 256;
    localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = {REG_OUTPUT_LIMIT, 2'b00};

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            coded_byte;
    logic                  last_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic                  is_status;
    logic [7:0]            symbol;
    logic [1:0]            status_code;
    logic [COUNT_W-1:0]    decoded_count;
    logic                  last_result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Decoder state mirrored by the testbench.
    logic [NODE_W-1:0]  walk_node;
    logic [COUNT_W-1:0] walk_count;
    status_t            walk_error;
    bit                 walk_closed;
    logic [COUNT_W-1:0] limit_shadow;

    // Transactions the decoder still owes, oldest first.
    result_t expected_items[$];

    // Huffman code of every symbol, derived from the decode tree.
    logic [31:0] sym_code [0:EOS_SYMBOL];
    int          sym_len  [0:EOS_SYMBOL];

    // Symbols of the string being built and its coded bytes.
    int          string_syms[$];
    logic [7:0]  coded_bytes[$];

    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned bytes_sent;
    bit          gaps_on;

    hpack_huffman_tree_decoder_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .coded_byte    (coded_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .is_status     (is_status),
        .symbol        (symbol),
        .status_code   (status_code),
        .decoded_count (decoded_count),
        .last_result   (last_result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock with a 10 unit period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The receiver stalls at random while gaps are enabled.
    always @(posedge clk)
    begin
        out_ready <= !gaps_on || ($urandom_range(99) >= 30);
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_hpack_huffman_tree_decoder_top failed");
            $finish;
        end
    end

    function automatic void flag_mismatch(input string what, input int unsigned want,
                                          input int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    // Compare every output transaction with the oldest expected one.
    always @(posedge clk)
    begin : check_outputs
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_items.size() == 0)
            begin
                flag_mismatch("transaction with none expected, count", 0, decoded_count);
            end
            else
            begin
                want = expected_items.pop_front();
                if (is_status !== want.is_status)
                    flag_mismatch("is_status", want.is_status, is_status);
                if (symbol !== want.symbol)
                    flag_mismatch("symbol", want.symbol, symbol);
                if (status_code !== want.status_code)
                    flag_mismatch("status_code", want.status_code, status_code);
                if (decoded_count !== want.decoded_count)
                    flag_mismatch("decoded_count", want.decoded_count, decoded_count);
                if (last_result !== want.last_result)
                    flag_mismatch("last_result", want.last_result, last_result);
            end
        end
    end

    // Walk one coded byte through the tree and queue the transactions it causes.
    // The newest symbol is held back so that the final one can carry last_result.
    function automatic void walk_coded_byte(input logic [7:0] cb, input logic lb);
        logic [31:0] word;
        logic [15:0] child;
        logic [7:0]  pad;
        result_t     held;
        bit          have_held;
        have_held = 1'b0;
        held      = '0;
        // A count already at the limit blocks the byte before any bit is walked.
        if (walk_error == ST_OK && !walk_closed && walk_count >= limit_shadow)
            walk_error = ST_OVERFLOW;
        for (int k = 0; k < 8; k++)
        begin
            if (walk_error != ST_OK || walk_closed)
                break;
            word  = DECODE_TREE[walk_node];
            child = cb[7-k] ? word[15:0] : word[31:16];
            if (!child[LEAF_BIT])
            begin
                walk_node = child[NODE_W-1:0];
                continue;
            end
            walk_node = '0;
            if (child[14:0] > 15'd255)
            begin
                walk_error = ST_EOS;
                walk_count = '0;
                break;
            end
            if (have_held)
                expected_items.push_back(held);
            walk_count            = walk_count + 1'b1;
            held.is_status        = 1'b0;
            held.symbol           = child[7:0];
            held.status_code      = ST_OK;
            held.decoded_count    = walk_count;
            held.last_result      = 1'b0;
            have_held             = 1'b1;
            // All ones after a symbol in the last byte is the padding of a clean end.
            pad = 8'h7F >> k;
            if (lb && (cb & pad) == pad)
                walk_closed = 1'b1;
            else if (walk_count >= limit_shadow)
                walk_error = ST_OVERFLOW;
        end
        // The last byte closes the string with a status transaction.
        if (lb)
        begin
            if (have_held)
                expected_items.push_back(held);
            held.is_status     = 1'b1;
            held.symbol        = 8'd0;
            held.status_code   = (walk_error != ST_OK) ? walk_error :
                                 (walk_closed ? ST_OK : ST_TRUNC);
            held.decoded_count = (walk_error == ST_EOS) ? '0 : walk_count;
            held.last_result   = 1'b0;
            have_held          = 1'b1;
            walk_node          = '0;
            walk_count         = '0;
            walk_error         = ST_OK;
            walk_closed        = 1'b0;
        end
        if (have_held)
        begin
            held.last_result = 1'b1;
            expected_items.push_back(held);
        end
    endfunction

    // Derive the code of every leaf by a breadth-first pass over the tree.
    function automatic void build_code_table();
        int          open_nodes[$];
        logic [31:0] node_code [TREE_NODES];
        int          node_len  [TREE_NODES];
        int          n;
        int          leaf;
        logic [31:0] word;
        logic [15:0] child;
        node_code[0] = '0;
        node_len[0]  = 0;
        open_nodes.push_back(0);
        while (open_nodes.size() != 0)
        begin
            n    = open_nodes.pop_front();
            word = DECODE_TREE[n];
            for (int b = 0; b < 2; b++)
            begin
                child = (b == 1) ? word[15:0] : word[31:16];
                if (child[LEAF_BIT])
                begin
                    leaf = int'(child[14:0]);
                    if (leaf <= EOS_SYMBOL)
                    begin
                        sym_code[leaf] = (node_code[n] << 1) | b;
                        sym_len[leaf]  = node_len[n] + 1;
                    end
                end
                else
                begin
                    node_code[child[NODE_W-1:0]] = (node_code[n] << 1) | b;
                    node_len[child[NODE_W-1:0]]  = node_len[n] + 1;
                    open_nodes.push_back(int'(child[NODE_W-1:0]));
                end
            end
        end
    endfunction

    // Pack the symbols of string_syms into coded_bytes, filling the tail with pad_bit.
    function automatic void encode_symbols(input bit pad_bit);
        bit         bits[$];
        logic [7:0] acc;
        int         s;
        coded_bytes.delete();
        foreach (string_syms[i])
        begin
            s = string_syms[i];
            for (int j = sym_len[s] - 1; j >= 0; j--)
                bits.push_back(sym_code[s][j]);
        end
        while (bits.size() % 8 != 0)
            bits.push_back(pad_bit);
        for (int i = 0; i < bits.size(); i += 8)
        begin
            for (int j = 0; j < 8; j++)
                acc[7-j] = bits[i+j];
            coded_bytes.push_back(acc);
        end
    endfunction

    // Send one coded byte and predict its results once it is accepted.
    task automatic push_coded_byte(input logic [7:0] cb, input logic lb);
        while (gaps_on && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        coded_byte <= cb;
        last_byte  <= lb;
        do
            @(posedge clk);
        while (!in_ready);
        walk_coded_byte(cb, lb);
        bytes_sent++;
    endtask

    // Send coded_bytes as one string, optionally cutting off its final byte.
    task automatic send_coded_string(input bit drop_last);
        int n;
        n = coded_bytes.size();
        if (drop_last && n > 1)
            n--;
        for (int i = 0; i < n; i++)
            push_coded_byte(coded_bytes[i], i == n - 1);
    endtask

    task automatic send_symbols(input bit pad_bit);
        encode_symbols(pad_bit);
        send_coded_string(1'b0);
    endtask

    // Wait until every expected transaction has arrived and the walker is done.
    task automatic wait_decoder_idle();
        in_valid <= 1'b0;
        while (expected_items.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
                            output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write the output limit, then read it back.
    task automatic set_output_limit(input logic [COUNT_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit_shadow = value;
        @(posedge clk);
        apb_read(LIMIT_ADDR, rd);
        if (rd[COUNT_W-1:0] !== value)
            flag_mismatch("output_limit readback", value, rd[COUNT_W-1:0]);
    endtask

    function automatic int pick_symbol();
        if ($urandom_range(99) < 55)
            return $urandom_range(32, 126);
        return $urandom_range(0, 255);
    endfunction

    // The limit register comes out of reset at its documented value.
    task automatic test_register_reset();
        logic [APB_DATA_W-1:0] rd;
        apb_read(LIMIT_ADDR, rd);
        if (rd[COUNT_W-1:0] !== LIMIT_RESET)
            flag_mismatch("output_limit after reset", LIMIT_RESET, rd[COUNT_W-1:0]);
    endtask

    // Clean ends, truncation, EOS and the extreme byte values.
    task automatic test_directed_strings();
        // One short symbol padded with ones: a clean end inside the byte.
        string_syms = '{97};
        send_symbols(1'b1);
        // Long codes: the first byte completes no symbol at all.
        string_syms = '{0};
        send_symbols(1'b1);
        string_syms = '{255, 48, 122};
        send_symbols(1'b1);
        // All zeros and all ones as lone last bytes.
        push_coded_byte(8'h00, 1'b1);
        push_coded_byte(8'hFF, 1'b1);
        // Zero padding leaves the string truncated.
        string_syms = '{97, 98};
        send_symbols(1'b0);
        // A string whose final byte never arrives flagged.
        string_syms = '{120, 121, 65};
        encode_symbols(1'b1);
        send_coded_string(1'b1);
        // EOS inside the string: error, count cleared, the rest dropped.
        string_syms = '{97, EOS_SYMBOL, 98, 99};
        send_symbols(1'b1);
        wait_decoder_idle();
    endtask

    // Overflow at the limit, at a zero limit and after a limit lowered mid-string.
    task automatic test_output_limit();
        set_output_limit(16'd0);
        string_syms = '{97};
        send_symbols(1'b1);
        string_syms = '{97, 98, 99};
        send_symbols(1'b1);
        wait_decoder_idle();
        set_output_limit(16'd2);
        // Reaching the limit on the clean-end symbol is still a clean end.
        string_syms = '{97, 98};
        send_symbols(1'b1);
        string_syms = '{97, 98, 99, 100};
        send_symbols(1'b1);
        wait_decoder_idle();
        set_output_limit(LIMIT_RESET);
        string_syms = '{97, 98, 99, 100, 101, 102};
        encode_symbols(1'b1);
        for (int i = 0; i < coded_bytes.size() - 1; i++)
            push_coded_byte(coded_bytes[i], 1'b0);
        wait_decoder_idle();
        set_output_limit(16'd1);
        push_coded_byte(coded_bytes[coded_bytes.size()-1], 1'b1);
        wait_decoder_idle();
    endtask

    // Mostly well-formed strings with random content, the rest broken or noise.
    task automatic test_random_strings(input logic [COUNT_W-1:0] limit, input int n_bytes,
                                       input bit with_gaps);
        int unsigned target;
        int          kind;
        int          len;
        set_output_limit(limit);
        gaps_on = with_gaps;
        target  = bytes_sent + n_bytes;
        while (bytes_sent < target)
        begin
            kind = $urandom_range(99);
            string_syms.delete();
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                string_syms.push_back(pick_symbol());
            if (kind < 70)
            begin
                send_symbols(1'b1);
            end
            else if (kind < 78)
            begin
                send_symbols(1'b0);
            end
            else if (kind < 84)
            begin
                encode_symbols(1'b1);
                send_coded_string(1'b1);
            end
            else if (kind < 90)
            begin
                string_syms.insert($urandom_range(0, len), EOS_SYMBOL);
                send_symbols(1'b1);
            end
            else
            begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    push_coded_byte(8'($urandom_range(0, 255)), i == len - 1);
            end
        end
        wait_decoder_idle();
    endtask

    // Reset, then run every test in turn.
    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        coded_byte   <= '0;
        last_byte    <= 1'b0;
        out_ready    <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        cycle_count  = 0;
        mismatches   = 0;
        bytes_sent   = 0;
        gaps_on      = 1'b1;
        walk_node    = '0;
        walk_count   = '0;
        walk_error   = ST_OK;
        walk_closed  = 1'b0;
        limit_shadow = LIMIT_RESET;
        build_code_table();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_directed_strings();
        test_output_limit();
        test_random_strings(LIMIT_RESET, 80, 1'b1);
        test_random_strings(16'($urandom_range(1, 6)), 70, 1'b1);
        test_random_strings(16'hFFFF, 80, 1'b0);

        wait_decoder_idle();
        if (mismatches == 0 && expected_items.size() == 0)
            $display("tb_hpack_huffman_tree_decoder_top passed");
        else
            $display("tb_hpack_huffman_tree_decoder_top failed");
        $finish;
    end

endmodule
